// ----- rtl/mswe_pkg.sv -----
// Package for the marquee scroll window engine.
// Holds the configuration layout, register codes, queue entry type and limits.
// No dependencies.
`default_nettype none

package mswe_pkg;

  localparam int COORD_BITS = 16;
  localparam int OMAX = (COORD_BITS >= 16) ? 32767 : (2 ** (COORD_BITS - 1)) - 1;

  localparam int ACC_W = 17;
  localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int OPT_ONCE = 0;
  localparam int OPT_RTL  = 1;

  localparam logic MODE_BOUNCE = 1'b0;
  localparam logic MODE_WRAP   = 1'b1;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TICK_PERIOD    = 3'd0,
    REG_STEP_SIZE      = 3'd1,
    REG_OVERFLOW_LIMIT = 3'd2,
    REG_WINDOW_LEN     = 3'd3,
    REG_CONTENT_LEN    = 3'd4,
    REG_LOOP_GAP       = 3'd5,
    REG_SCROLL_MODE    = 3'd6,
    REG_OPTIONS        = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic        [15:0] tick_period;
    logic        [7:0]  step_size;
    logic signed [15:0] overflow_limit;
    logic        [12:0] window_len;
    logic        [14:0] content_len;
    logic        [9:0]  loop_gap;
    logic               scroll_mode;
    logic        [1:0]  options;
  } cfg_t;

  // one tick's result after the state update, waiting for segment mapping
  typedef struct packed {
    logic signed [15:0] offset;
    logic               done;
    logic               stepped;
  } qent_t;

endpackage

`default_nettype wire

// ----- rtl/mswe_if.sv -----
// Channel interfaces for the marquee scroll window engine: tick input,
// result output and configuration write. No dependencies.
`default_nettype none

interface mswe_tick_if;
  logic        valid;
  logic        ready;
  logic [15:0] elapsed_ms;
  logic        hold;
  logic        restart;
  modport source (output valid, elapsed_ms, hold, restart, input ready);
  modport sink   (input valid, elapsed_ms, hold, restart, output ready);
endinterface

interface mswe_res_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] scroll_offset;
  logic               done_res;
  logic               stepped;
  logic               seg1_valid;
  logic        [14:0] seg1_src;
  logic        [12:0] seg1_len;
  logic        [12:0] seg1_dst;
  logic               seg2_valid;
  logic        [14:0] seg2_src;
  logic        [12:0] seg2_len;
  logic        [12:0] seg2_dst;
  modport source (output valid, scroll_offset, done_res, stepped, seg1_valid, seg1_src,
                  seg1_len, seg1_dst, seg2_valid, seg2_src, seg2_len, seg2_dst,
                  input ready);
  modport sink   (input valid, scroll_offset, done_res, stepped, seg1_valid, seg1_src,
                  seg1_len, seg1_dst, seg2_valid, seg2_src, seg2_len, seg2_dst,
                  output ready);
endinterface

interface mswe_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- rtl/marquee_scroll_window_engine.sv -----
// Marquee scroll window engine, top level: configuration registers, front end,
// queue and segment mapper. Depends on mswe_pkg, mswe_if, mswe_front, mswe_fifo, mswe_back.
// A result passes through the queue and then the output register before res.valid
// rises; a stalled result can hold it in the queue.
// Throughput: one tick per cycle; ticks stall only while the two-entry queue is full
// behind a stalled result. Reset: synchronous, clears scroll state and queue, loads defaults.
`default_nettype none

module marquee_scroll_window_engine
  import mswe_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  mswe_tick_if.sink  tick,
  mswe_res_if.source res,
  mswe_cfg_if.sink   cfg
);

  cfg_t  regs;
  logic  q_push, q_in_ready, q_valid, q_pop;
  qent_t q_in, q_out;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.tick_period    <= 16'd20;
      regs.step_size      <= 8'd1;
      regs.overflow_limit <= 16'sd0;
      regs.window_len     <= 13'd128;
      regs.content_len    <= 15'd0;
      regs.loop_gap       <= 10'd16;
      regs.scroll_mode    <= MODE_BOUNCE;
      regs.options        <= 2'd0;
    end else if (cfg.valid) begin
      unique case (cfg_reg_e'(cfg.index))
        REG_TICK_PERIOD:    regs.tick_period    <= cfg.data;
        REG_STEP_SIZE:      regs.step_size      <= cfg.data[7:0];
        REG_OVERFLOW_LIMIT: regs.overflow_limit <= $signed(cfg.data);
        REG_WINDOW_LEN:     regs.window_len     <= cfg.data[12:0];
        REG_CONTENT_LEN:    regs.content_len    <= cfg.data[14:0];
        REG_LOOP_GAP:       regs.loop_gap       <= cfg.data[9:0];
        REG_SCROLL_MODE:    regs.scroll_mode    <= cfg.data[0];
        REG_OPTIONS:        regs.options        <= cfg.data[1:0];
        default: ;
      endcase
    end
  end

  mswe_front u_front (
    .clk     (clk),
    .rst     (rst),
    .tick    (tick),
    .cfg     (regs),
    .q_ready (q_in_ready),
    .q_push  (q_push),
    .q_data  (q_in)
  );

  mswe_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .in_ready  (q_in_ready),
    .pop       (q_pop),
    .out_valid (q_valid),
    .out_data  (q_out)
  );

  mswe_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (regs),
    .q_valid (q_valid),
    .q_data  (q_out),
    .q_pop   (q_pop),
    .res     (res)
  );

endmodule

`default_nettype wire

// ----- rtl/mswe_front.sv -----
// Front end: accepts tick transactions and updates accumulator, offset,
// direction and done state. Depends on mswe_pkg and mswe_tick_if.
`default_nettype none

module mswe_front
  import mswe_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  mswe_tick_if.sink  tick,
  input  wire cfg_t  cfg,
  input  wire logic  q_ready,
  output logic       q_push,
  output qent_t      q_data
);

  logic [ACC_W-1:0]   ms_accum, ms_accum_next;
  logic signed [15:0] offset_reg, offset_reg_next;
  logic               dir_negative, dir_negative_next;
  logic               finished, finished_next;

  logic               rtl, once;
  logic               fin_a, dir_a;
  logic signed [15:0] off_a;
  logic [ACC_W:0]     acc_sum;
  logic [ACC_W-1:0]   acc_sat;
  logic               take;
  logic signed [17:0] mv, n, abs_n, lim, thr, limit_x, n_c;
  logic               stepped;

  localparam logic signed [17:0] OMAX_X = 18'(OMAX);

  assign tick.ready = q_ready;
  assign q_push     = tick.valid && q_ready;

  always_comb begin
    rtl   = cfg.options[OPT_RTL];
    once  = cfg.options[OPT_ONCE];
    fin_a = tick.restart ? 1'b0 : finished;
    off_a = tick.restart ? 16'sd0 : offset_reg;
    dir_a = tick.restart ? rtl : dir_negative;

    acc_sum = {1'b0, ms_accum} + {2'b00, tick.elapsed_ms};
    acc_sat = acc_sum[ACC_W] ? ACC_MAX : acc_sum[ACC_W-1:0];
    take    = acc_sat >= {1'b0, cfg.tick_period};

    limit_x = 18'(cfg.overflow_limit);
    mv      = $signed({10'b0, cfg.step_size});
    n       = 18'(off_a) + (dir_a ? mv : (18'sd0 - mv));
    abs_n   = n[17] ? (18'sd0 - n) : n;
    lim     = (limit_x < OMAX_X) ? limit_x : OMAX_X;
    thr     = limit_x + $signed({5'b0, cfg.window_len}) + $signed({8'b0, cfg.loop_gap});

    ms_accum_next     = ms_accum;
    offset_reg_next   = off_a;
    dir_negative_next = dir_a;
    finished_next     = fin_a;
    stepped           = 1'b0;
    n_c               = n;

    if (!tick.hold && !fin_a) begin
      if (cfg.overflow_limit[15] || cfg.overflow_limit == 16'sd0) begin
        offset_reg_next = 16'sd0;
        if (once) finished_next = 1'b1;
      end else begin
        ms_accum_next = acc_sat;
        if (take) begin
          ms_accum_next = acc_sat - {1'b0, cfg.tick_period};
          stepped       = 1'b1;
          if (cfg.scroll_mode == MODE_BOUNCE) begin
            if (abs_n > lim) begin
              n_c               = n[17] ? (18'sd0 - lim) : lim;
              dir_negative_next = !dir_a;
              if (once) finished_next = 1'b1;
            end
          end else begin
            if (abs_n > thr || abs_n > OMAX_X) begin
              n_c               = 18'sd0;
              dir_negative_next = rtl;
              if (once) finished_next = 1'b1;
            end
          end
          offset_reg_next = n_c[15:0];
        end
      end
    end

    q_data.offset  = offset_reg_next;
    q_data.done    = finished_next;
    q_data.stepped = stepped;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ms_accum     <= '0;
      offset_reg   <= '0;
      dir_negative <= 1'b0;
      finished     <= 1'b0;
    end else if (q_push) begin
      ms_accum     <= ms_accum_next;
      offset_reg   <= offset_reg_next;
      dir_negative <= dir_negative_next;
      finished     <= finished_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/mswe_fifo.sv -----
// Short queue between the front end and the segment mapper.
// Depends on mswe_pkg (depth, entry type).
`default_nettype none

module mswe_fifo
  import mswe_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire qent_t push_data,
  output logic       in_ready,
  input  wire logic  pop,
  output logic       out_valid,
  output qent_t      out_data
);

  qent_t             mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;

  assign in_ready  = count != QCNT_W'(QDEPTH);
  assign out_valid = count != '0;
  assign out_data  = mem[rd_ptr];

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= ptr_inc(wr_ptr);
      if (pop)  rd_ptr <= ptr_inc(rd_ptr);
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QDEPTH))
    else $error("queue count above depth");
  a_push_only: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + 1'b1)
    else $error("queue count did not grow on push");
  a_pop_only: assert property (@(posedge clk) disable iff (rst)
    !push && pop |=> count == $past(count) - 1'b1)
    else $error("queue count did not shrink on pop");
  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    pop |-> out_valid)
    else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire

// ----- rtl/mswe_back.sv -----
// Back end: maps the queued offset to the two window segments and holds the
// result in an output register. Depends on mswe_pkg and mswe_res_if.
`default_nettype none

module mswe_back
  import mswe_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire cfg_t  cfg,
  input  wire logic  q_valid,
  input  wire qent_t q_data,
  output logic       q_pop,
  mswe_res_if.source res
);

  typedef struct packed {
    logic signed [15:0] scroll_offset;
    logic               done_res;
    logic               stepped;
    logic               seg1_valid;
    logic        [14:0] seg1_src;
    logic        [12:0] seg1_len;
    logic        [12:0] seg1_dst;
    logic               seg2_valid;
    logic        [14:0] seg2_src;
    logic        [12:0] seg2_len;
    logic        [12:0] seg2_dst;
  } res_t;

  res_t               res_q, res_next;
  logic               res_valid;
  logic               mirror;
  logic signed [18:0] t, w, gap, off, s1, s1w, vs, ve, w2, w2c, len2, d1, d2;

  assign q_pop = q_valid && (!res_valid || res.ready);

  always_comb begin
    mirror = cfg.options[OPT_RTL];
    t      = $signed({4'b0, cfg.content_len});
    w      = $signed({6'b0, cfg.window_len});
    gap    = $signed({9'b0, cfg.loop_gap});
    off    = 19'(q_data.offset);
    s1     = mirror ? (t - w - off) : (19'sd0 - off);
    s1w    = s1 + w;
    vs     = s1[18] ? 19'sd0 : s1;
    ve     = (s1w > t) ? t : s1w;
    w2     = mirror ? (19'sd0 - (s1 + gap)) : (s1w - (t + gap));
    w2c    = (w2 > w) ? w : w2;
    len2   = (w2c > t) ? t : w2c;
    d1     = ve - vs;
    d2     = vs - s1;

    res_next               = '0;
    res_next.scroll_offset = q_data.offset;
    res_next.done_res      = q_data.done;
    res_next.stepped       = q_data.stepped;
    if (ve > vs) begin
      res_next.seg1_valid = 1'b1;
      res_next.seg1_src   = vs[14:0];
      res_next.seg1_len   = d1[12:0];
      res_next.seg1_dst   = d2[12:0];
    end
    if (cfg.scroll_mode == MODE_WRAP && w2 > 19'sd0 && len2 > 19'sd0) begin
      res_next.seg2_valid = 1'b1;
      res_next.seg2_len   = len2[12:0];
      if (mirror) begin
        res_next.seg2_src = 15'(t - len2);
        res_next.seg2_dst = 13'(w2c - len2);
      end else begin
        res_next.seg2_src = '0;
        res_next.seg2_dst = 13'(w - w2c);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (q_pop) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) res_q <= res_next;
  end

  assign res.valid         = res_valid;
  assign res.scroll_offset = res_q.scroll_offset;
  assign res.done_res      = res_q.done_res;
  assign res.stepped       = res_q.stepped;
  assign res.seg1_valid    = res_q.seg1_valid;
  assign res.seg1_src      = res_q.seg1_src;
  assign res.seg1_len      = res_q.seg1_len;
  assign res.seg1_dst      = res_q.seg1_dst;
  assign res.seg2_valid    = res_q.seg2_valid;
  assign res.seg2_src      = res_q.seg2_src;
  assign res.seg2_len      = res_q.seg2_len;
  assign res.seg2_dst      = res_q.seg2_dst;

endmodule

`default_nettype wire

// ----- tb/sv/marquee_scroll_window_engine_test.sv -----
// Self-checking testbench for marquee_scroll_window_engine: directed and random tick
// transactions under bursty input and stalled output, checked against a scroll predictor.
// Depends on mswe_pkg, mswe_if and the engine RTL.
`timescale 1ns / 100ps

module marquee_scroll_window_engine_test;
  import mswe_pkg::*;

  localparam int RANDOM_ITEMS = 1500;
  localparam int CYCLE_LIMIT  = 600000;

  typedef struct packed {
    logic [15:0] elapsed_ms;
    logic        hold;
    logic        restart;
  } tick_item_t;

  typedef struct packed {
    logic signed [15:0] scroll_offset;
    logic               done_res;
    logic               stepped;
    logic               seg1_valid;
    logic        [14:0] seg1_src;
    logic        [12:0] seg1_len;
    logic        [12:0] seg1_dst;
    logic               seg2_valid;
    logic        [14:0] seg2_src;
    logic        [12:0] seg2_len;
    logic        [12:0] seg2_dst;
  } scroll_frame_t;

  logic clk;
  logic rst;

  mswe_tick_if tick_ch ();
  mswe_res_if  res_ch ();
  mswe_cfg_if  cfg_ch ();

  marquee_scroll_window_engine dut (
    .clk  (clk),
    .rst  (rst),
    .tick (tick_ch),
    .res  (res_ch),
    .cfg  (cfg_ch)
  );

  tick_item_t    ticks_pending[$];
  scroll_frame_t frames_due[$];
  int            mismatch_count = 0;
  int            cycles = 0;

  // predictor state
  cfg_t model_cfg;
  int   acc_ms;
  int   pos;
  bit   moves_up;
  bit   halted;

  int   burst_left;
  int   gap_left;
  int   rx_left;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input logic signed [31:0] got,
                                 input logic signed [31:0] want);
    mismatch_count++;
    if (mismatch_count <= 100)
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  function automatic scroll_frame_t advance_marquee(input logic [15:0] elapsed,
                                                    input logic hold, input logic restart);
    scroll_frame_t f;
    bit mirror;
    bit once;
    int acc, nxt, limit, lim, thr, t, w, gap, s1, vs, ve, w2, span;
    f = '0;
    mirror = model_cfg.options[OPT_RTL];
    once = model_cfg.options[OPT_ONCE];
    limit = int'($signed(model_cfg.overflow_limit));
    if (restart) begin
      halted = 1'b0;
      pos = 0;
      moves_up = mirror;
    end
    if (!hold && !halted) begin
      if (limit <= 0) begin
        pos = 0;
        if (once) halted = 1'b1;
      end else begin
        acc = acc_ms + int'(elapsed);
        if (acc > int'(ACC_MAX)) acc = int'(ACC_MAX);
        if (acc >= int'(model_cfg.tick_period)) begin
          acc = acc - int'(model_cfg.tick_period);
          nxt = moves_up ? pos + int'(model_cfg.step_size) : pos - int'(model_cfg.step_size);
          if (model_cfg.scroll_mode == MODE_BOUNCE) begin
            lim = (limit < OMAX) ? limit : OMAX;
            if ((nxt < 0 ? -nxt : nxt) > lim) begin
              nxt = (nxt > 0) ? lim : -lim;
              moves_up = !moves_up;
              if (once) halted = 1'b1;
            end
          end else begin
            thr = limit + int'(model_cfg.window_len) + int'(model_cfg.loop_gap);
            if ((nxt < 0 ? -nxt : nxt) > thr || (nxt < 0 ? -nxt : nxt) > OMAX) begin
              nxt = 0;
              moves_up = mirror;
              if (once) halted = 1'b1;
            end
          end
          pos = nxt;
          f.stepped = 1'b1;
        end
        acc_ms = acc;
      end
    end
    f.scroll_offset = pos[15:0];
    f.done_res = halted;

    t = int'(model_cfg.content_len);
    w = int'(model_cfg.window_len);
    gap = int'(model_cfg.loop_gap);
    s1 = mirror ? t - w - pos : -pos;
    vs = (s1 < 0) ? 0 : s1;
    ve = (s1 + w > t) ? t : s1 + w;
    if (ve > vs) begin
      f.seg1_valid = 1'b1;
      f.seg1_src = vs[14:0];
      span = ve - vs;
      f.seg1_len = span[12:0];
      span = vs - s1;
      f.seg1_dst = span[12:0];
    end
    if (model_cfg.scroll_mode == MODE_WRAP) begin
      w2 = mirror ? -(s1 + gap) : s1 + w - (t + gap);
      if (w2 > 0) begin
        if (w2 > w) w2 = w;
        span = (w2 > t) ? t : w2;
        if (span > 0) begin
          f.seg2_valid = 1'b1;
          f.seg2_len = span[12:0];
          if (mirror) begin
            t = t - span;
            f.seg2_src = t[14:0];
            w2 = w2 - span;
            f.seg2_dst = w2[12:0];
          end else begin
            w2 = w - w2;
            f.seg2_dst = w2[12:0];
          end
        end
      end
    end
    return f;
  endfunction

  // tick driver: bursts of random length, random gaps in between
  always @(posedge clk) begin : tick_driver
    tick_item_t nxt;
    if (rst) begin
      tick_ch.valid <= 1'b0;
      tick_ch.elapsed_ms <= '0;
      tick_ch.hold <= 1'b0;
      tick_ch.restart <= 1'b0;
      burst_left <= 1;
      gap_left <= 0;
    end else if (!tick_ch.valid || tick_ch.ready) begin
      if (gap_left > 0) begin
        tick_ch.valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (ticks_pending.size() != 0) begin
        nxt = ticks_pending.pop_front();
        tick_ch.valid <= 1'b1;
        tick_ch.elapsed_ms <= nxt.elapsed_ms;
        tick_ch.hold <= nxt.hold;
        tick_ch.restart <= nxt.restart;
        if (burst_left <= 1) begin
          burst_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
                                                    : $urandom_range(1, 12);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        tick_ch.valid <= 1'b0;
      end
    end
  end

  // result sink: open stretches alternate with stalls
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
      rx_left <= 0;
    end else if (rx_left > 0) begin
      rx_left <= rx_left - 1;
    end else if (res_ch.ready) begin
      res_ch.ready <= 1'b0;
      rx_left <= $urandom_range(0, 8);
    end else begin
      res_ch.ready <= 1'b1;
      rx_left <= ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 30);
    end
  end

  // monitor: checks results, predicts accepted ticks, tracks register writes
  always @(posedge clk) begin : monitor
    scroll_frame_t want;
    if (rst) begin
      model_cfg.tick_period = 16'd20;
      model_cfg.step_size = 8'd1;
      model_cfg.overflow_limit = 16'sd0;
      model_cfg.window_len = 13'd128;
      model_cfg.content_len = 15'd0;
      model_cfg.loop_gap = 10'd16;
      model_cfg.scroll_mode = MODE_BOUNCE;
      model_cfg.options = 2'd0;
      acc_ms = 0;
      pos = 0;
      moves_up = 1'b0;
      halted = 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (frames_due.size() == 0) begin
          report_mismatch("result with nothing pending", 1, 0);
        end else begin
          want = frames_due.pop_front();
          if (res_ch.scroll_offset !== want.scroll_offset)
            report_mismatch("scroll_offset", res_ch.scroll_offset, want.scroll_offset);
          if (res_ch.done_res !== want.done_res)
            report_mismatch("done_res", res_ch.done_res, want.done_res);
          if (res_ch.stepped !== want.stepped)
            report_mismatch("stepped", res_ch.stepped, want.stepped);
          if (res_ch.seg1_valid !== want.seg1_valid)
            report_mismatch("seg1_valid", res_ch.seg1_valid, want.seg1_valid);
          if (res_ch.seg1_src !== want.seg1_src)
            report_mismatch("seg1_src", res_ch.seg1_src, want.seg1_src);
          if (res_ch.seg1_len !== want.seg1_len)
            report_mismatch("seg1_len", res_ch.seg1_len, want.seg1_len);
          if (res_ch.seg1_dst !== want.seg1_dst)
            report_mismatch("seg1_dst", res_ch.seg1_dst, want.seg1_dst);
          if (res_ch.seg2_valid !== want.seg2_valid)
            report_mismatch("seg2_valid", res_ch.seg2_valid, want.seg2_valid);
          if (res_ch.seg2_src !== want.seg2_src)
            report_mismatch("seg2_src", res_ch.seg2_src, want.seg2_src);
          if (res_ch.seg2_len !== want.seg2_len)
            report_mismatch("seg2_len", res_ch.seg2_len, want.seg2_len);
          if (res_ch.seg2_dst !== want.seg2_dst)
            report_mismatch("seg2_dst", res_ch.seg2_dst, want.seg2_dst);
        end
      end
      if (tick_ch.valid && tick_ch.ready)
        frames_due.push_back(advance_marquee(tick_ch.elapsed_ms, tick_ch.hold,
                                             tick_ch.restart));
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_reg_e'(cfg_ch.index))
          REG_TICK_PERIOD:    model_cfg.tick_period = cfg_ch.data;
          REG_STEP_SIZE:      model_cfg.step_size = cfg_ch.data[7:0];
          REG_OVERFLOW_LIMIT: model_cfg.overflow_limit = cfg_ch.data;
          REG_WINDOW_LEN:     model_cfg.window_len = cfg_ch.data[12:0];
          REG_CONTENT_LEN:    model_cfg.content_len = cfg_ch.data[14:0];
          REG_LOOP_GAP:       model_cfg.loop_gap = cfg_ch.data[9:0];
          REG_SCROLL_MODE:    model_cfg.scroll_mode = cfg_ch.data[0];
          REG_OPTIONS:        model_cfg.options = cfg_ch.data[1:0];
          default: ;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // called at a rising edge; valid stays high for back-to-back writes
  task automatic write_reg(input cfg_reg_e idx, input logic [15:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  task automatic queue_tick(input int elapsed, input bit hold, input bit restart);
    tick_item_t item;
    item.elapsed_ms = elapsed[15:0];
    item.hold = hold;
    item.restart = restart;
    ticks_pending.push_back(item);
  endtask

  // sampled at the falling edge, where driver and monitor updates have settled
  task automatic settle();
    while (ticks_pending.size() != 0 || tick_ch.valid || frames_due.size() != 0)
      @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin : stimulus
    int placed, turn, batch, period, step, limit, win, content, gap, hi;
    bit deep;
    rst <= 1'b1;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= REG_TICK_PERIOD;
    cfg_ch.data <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // defaults: no overhang, empty content
    @(negedge clk);
    queue_tick(20, 1'b0, 1'b0);
    queue_tick(65535, 1'b0, 1'b1);
    queue_tick(0, 1'b1, 1'b0);
    settle();

    // bounce, zero period, step overshoots the clamp both ways
    write_reg(REG_TICK_PERIOD, 16'd0);
    write_reg(REG_STEP_SIZE, 16'd255);
    write_reg(REG_OVERFLOW_LIMIT, 16'd5);
    write_reg(REG_WINDOW_LEN, 16'd8);
    write_reg(REG_CONTENT_LEN, 16'd13);
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
    repeat (3) queue_tick(0, 1'b0, 1'b0);
    queue_tick(7, 1'b1, 1'b0);
    queue_tick(0, 1'b0, 1'b0);
    settle();

    // one-shot: finish at the clamp, then restart together with hold
    write_reg(REG_OPTIONS, 16'd1);
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
    queue_tick(0, 1'b0, 1'b0);
    queue_tick(0, 1'b0, 1'b0);
    queue_tick(0, 1'b1, 1'b1);
    queue_tick(0, 1'b0, 1'b0);
    settle();

    // wrap, mirrored, accumulator saturation
    write_reg(REG_SCROLL_MODE, 16'(MODE_WRAP));
    write_reg(REG_OPTIONS, 16'd2);
    write_reg(REG_TICK_PERIOD, 16'd1);
    write_reg(REG_STEP_SIZE, 16'd3);
    write_reg(REG_OVERFLOW_LIMIT, 16'd4);
    write_reg(REG_WINDOW_LEN, 16'd10);
    write_reg(REG_CONTENT_LEN, 16'd14);
    write_reg(REG_LOOP_GAP, 16'd0);
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
    queue_tick(0, 1'b0, 1'b1);
    repeat (3) queue_tick(65535, 1'b0, 1'b0);
    repeat (3) queue_tick(1, 1'b0, 1'b0);
    settle();

    // most negative limit with one-shot, empty window, widest content and gap
    write_reg(REG_OVERFLOW_LIMIT, 16'h8000);
    write_reg(REG_OPTIONS, 16'd3);
    write_reg(REG_WINDOW_LEN, 16'd0);
    write_reg(REG_CONTENT_LEN, 16'd32767);
    write_reg(REG_LOOP_GAP, 16'd1023);
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
    queue_tick(100, 1'b0, 1'b0);
    queue_tick(100, 1'b0, 1'b0);
    queue_tick(0, 1'b0, 1'b1);
    settle();

    placed = 0;
    turn = 0;
    while (placed < RANDOM_ITEMS) begin
      turn++;
      deep = (turn % 5 == 0);
      case ($urandom_range(0, 9))
        0: period = 1;
        1: period = 65535;
        2: period = 0;
        3: period = $urandom_range(0, 65535);
        default: period = $urandom_range(1, 40);
      endcase
      case ($urandom_range(0, 9))
        0: step = 255;
        1: step = 1;
        default: step = $urandom_range(1, 12);
      endcase
      case ($urandom_range(0, 9))
        0: limit = -32768;
        1: limit = 0;
        2: limit = 32767;
        3: limit = $urandom_range(0, 65535) - 32768;
        4: limit = -$urandom_range(1, 100);
        default: limit = $urandom_range(1, 120);
      endcase
      case ($urandom_range(0, 11))
        0: win = 0;
        1: win = 4096;
        2: win = 8191;
        3: win = 1;
        default: win = $urandom_range(2, 200);
      endcase
      gap = ($urandom_range(0, 5) == 0) ? 1023 : $urandom_range(0, 40);
      if (deep) begin
        period = $urandom_range(0, 1);
        step = $urandom_range(128, 255);
        limit = ($urandom_range(0, 1) != 0) ? 32767 : $urandom_range(20000, 32767);
        win = $urandom_range(4096, 8191);
      end
      case ($urandom_range(0, 5))
        0: content = 0;
        1: content = 32767;
        2: content = (win + (limit > 0 ? limit : 0) > 32767) ? 32767
                                                              : win + (limit > 0 ? limit : 0);
        default: content = $urandom_range(0, 400);
      endcase
      write_reg(REG_TICK_PERIOD, 16'(period));
      write_reg(REG_STEP_SIZE, 16'(step));
      write_reg(REG_OVERFLOW_LIMIT, 16'(limit));
      write_reg(REG_WINDOW_LEN, 16'(win));
      write_reg(REG_CONTENT_LEN, 16'(content));
      write_reg(REG_LOOP_GAP, 16'(gap));
      write_reg(REG_SCROLL_MODE, 16'($urandom_range(0, 1)));
      write_reg(REG_OPTIONS, 16'($urandom_range(0, 3)));
      cfg_ch.valid <= 1'b0;
      @(negedge clk);
      batch = deep ? 200 : $urandom_range(20, 90);
      hi = (2 * period + 1 > 65535) ? 65535 : 2 * period + 1;
      repeat (batch) begin
        case ($urandom_range(0, 9))
          0: queue_tick(0, $urandom_range(0, 9) == 0, $urandom_range(0, deep ? 199 : 24) == 0);
          1: queue_tick(65535, $urandom_range(0, 9) == 0,
                        $urandom_range(0, deep ? 199 : 24) == 0);
          2: queue_tick($urandom_range(0, 65535), $urandom_range(0, 9) == 0,
                        $urandom_range(0, deep ? 199 : 24) == 0);
          default: queue_tick(deep ? $urandom_range(1, 3) : $urandom_range(0, hi),
                              $urandom_range(0, 9) == 0,
                              $urandom_range(0, deep ? 199 : 24) == 0);
        endcase
      end
      placed += batch;
      settle();
    end

    settle();
    if (mismatch_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

// ----- marquee_scroll_window_engine.f -----
rtl/mswe_pkg.sv
rtl/mswe_if.sv
rtl/mswe_front.sv
rtl/mswe_fifo.sv
rtl/mswe_back.sv
rtl/marquee_scroll_window_engine.sv
tb/sv/marquee_scroll_window_engine_test.sv
